[sv/c_token_classifier_top_defines.svh]
// Assertion macros for the token classifier RTL.
// No dependencies; included by ctk_outq, which checks its own logic.
`ifndef C_TOKEN_CLASSIFIER_TOP_DEFINES_SVH
`define C_TOKEN_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define CTK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token classifier assertion failed");

// next-cycle implication
`define CTK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token classifier assertion failed");

`endif

[sv/ctk_pkg.sv]
// Types, word tables and constants for the token classifier.
// No dependencies; imported by ctk_lexer, ctk_outq and the top level.
package ctk_pkg;

    typedef enum logic [2:0] {
        CLS_ERROR    = 3'd0,
        CLS_RESERVED = 3'd1,
        CLS_INTEGER  = 3'd2,
        CLS_FLOAT    = 3'd3,
        CLS_OPERATOR = 3'd4,
        CLS_VARIABLE = 3'd5,
        CLS_STMT_END = 3'd6
    } t_class;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        t_class token_class;
        logic   last_of_run;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] num;
        t_out_beat  first;
        t_out_beat  second;
    } t_push;

    localparam int WORD_COUNT    = 27;
    localparam int KEYWORD_COUNT = 16;
    localparam int WORD_MAXLEN   = 7;
    localparam logic [3:0] POS_MAX = 4'd8;
    localparam int CTK_QDEPTH    = 4;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_MAXLEN] = '{
        '{"c", "o", "n", "s", "t", CH_NUL, CH_NUL},
        '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"t", "y", "p", "e", "d", "e", "f"},
        '{"f", "l", "o", "a", "t", CH_NUL, CH_NUL},
        '{"s", "t", "r", "u", "c", "t", CH_NUL},
        '{"d", "o", "u", "b", "l", "e", CH_NUL},
        '{"e", "n", "u", "m", CH_NUL, CH_NUL, CH_NUL},
        '{"l", "o", "n", "g", CH_NUL, CH_NUL, CH_NUL},
        '{"b", "r", "e", "a", "k", CH_NUL, CH_NUL},
        '{"s", "t", "a", "t", "i", "c", CH_NUL},
        '{"r", "e", "t", "u", "r", "n", CH_NUL},
        '{"v", "o", "i", "d", CH_NUL, CH_NUL, CH_NUL},
        '{"e", "x", "t", "e", "r", "n", CH_NUL},
        '{"c", "h", "a", "r", CH_NUL, CH_NUL, CH_NUL},
        '{"u", "n", "i", "o", "n", CH_NUL, CH_NUL},
        '{"g", "o", "t", "o", CH_NUL, CH_NUL, CH_NUL},
        '{"+", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"-", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"<", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"=", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"!", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"=", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"<", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{">", "=", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{">", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"/", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"*", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
        4'd5, 4'd3, 4'd7, 4'd5, 4'd6, 4'd6, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd4, 4'd6, 4'd4, 4'd5, 4'd4,
        4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1
    };

endpackage

[sv/c_token_classifier_top.sv]
// A result beat is in the result queue from the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; a ';' that closes a token queues two beats, and
// input stalls while the result queue has fewer than two free slots.
// Reset: i_rst_n synchronous, active low; clears token state and empties the queue.
// Depends on ctk_pkg, ctk_lexer and ctk_outq.
module c_token_classifier_top #(
    parameter int QDEPTH = ctk_pkg::CTK_QDEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ctk_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ctk_pkg::t_out_beat o_out_data
);
    import ctk_pkg::*;

    logic  accept;
    t_push push;

    assign accept = i_in_valid && !o_in_stall;

    ctk_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in_data),
        .o_push   (push)
    );

    ctk_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

[sv/ctk_lexer.sv]
// Token state and classification for the token classifier.
// Depends on ctk_pkg; produces up to two result beats per accepted byte.
module ctk_lexer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ctk_pkg::t_in_beat i_beat,
    output ctk_pkg::t_push    o_push
);
    import ctk_pkg::*;

    logic [3:0]            r_pos, n_pos;
    logic [WORD_COUNT-1:0] r_cand, n_cand;
    logic                  r_alldig, n_alldig;
    logic [1:0]            r_dots, n_dots;
    logic                  r_other, n_other;
    logic                  r_allword, n_allword;
    logic                  r_firstdig, n_firstdig;

    logic [7:0]            c;
    logic                  dig, word, space, semi, eoi, pending;
    logic [WORD_COUNT-1:0] hits;
    t_class                cls;

    assign c       = i_beat.char_code;
    assign eoi     = i_beat.end_of_input;
    assign dig     = c inside {[8'h30:8'h39]};
    assign word    = dig || (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
    assign space   = c inside {8'h20, [8'h09:8'h0D]};
    assign semi    = (c == CH_SEMI);
    assign pending = (r_pos != 4'd0);

    always_comb begin
        for (int k = 0; k < WORD_COUNT; k++) begin
            hits[k] = r_cand[k] && (r_pos == WORD_LEN[k]);
        end
        if (r_alldig) begin
            cls = CLS_INTEGER;
        end else if (|hits[KEYWORD_COUNT-1:0]) begin
            cls = CLS_RESERVED;
        end else if (|hits) begin
            cls = CLS_OPERATOR;
        end else if (r_dots == 2'd1 && !r_other) begin
            cls = CLS_FLOAT;
        end else if (r_allword && !r_firstdig) begin
            cls = CLS_VARIABLE;
        end else begin
            cls = CLS_ERROR;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_cand     = r_cand;
        n_alldig   = r_alldig;
        n_dots     = r_dots;
        n_other    = r_other;
        n_allword  = r_allword;
        n_firstdig = r_firstdig;
        o_push.num         = 2'd0;
        o_push.first       = '{token_class: cls, last_of_run: 1'b1};
        o_push.second      = '{token_class: CLS_STMT_END, last_of_run: 1'b1};
        if (i_accept) begin
            if (eoi || space || semi) begin
                n_pos      = 4'd0;
                n_cand     = '1;
                n_alldig   = 1'b1;
                n_dots     = 2'd0;
                n_other    = 1'b0;
                n_allword  = 1'b1;
                n_firstdig = 1'b0;
                if (eoi || space) begin
                    o_push.num = pending ? 2'd1 : 2'd0;
                end else if (pending) begin
                    o_push.num               = 2'd2;
                    o_push.first.last_of_run = 1'b0;
                end else begin
                    o_push.num   = 2'd1;
                    o_push.first = '{token_class: CLS_STMT_END, last_of_run: 1'b1};
                end
            end else begin
                for (int k = 0; k < WORD_COUNT; k++) begin
                    if (r_pos >= WORD_LEN[k]) begin
                        n_cand[k] = 1'b0;
                    end else if (WORD_TEXT[k][r_pos[2:0]] != c) begin
                        n_cand[k] = 1'b0;
                    end
                end
                n_alldig  = r_alldig && dig;
                n_allword = r_allword && word;
                if (c == CH_DOT) begin
                    if (r_dots != 2'd2) begin
                        n_dots = r_dots + 2'd1;
                    end
                end else if (!dig) begin
                    n_other = 1'b1;
                end
                if (!pending) begin
                    n_firstdig = dig;
                end
                n_pos = (r_pos < POS_MAX) ? r_pos + 4'd1 : POS_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 4'd0;
            r_cand     <= '1;
            r_alldig   <= 1'b1;
            r_dots     <= 2'd0;
            r_other    <= 1'b0;
            r_allword  <= 1'b1;
            r_firstdig <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_cand     <= n_cand;
            r_alldig   <= n_alldig;
            r_dots     <= n_dots;
            r_other    <= n_other;
            r_allword  <= n_allword;
            r_firstdig <= n_firstdig;
        end
    end

endmodule

[sv/ctk_outq.sv]
// Classifier result queue: up to two beats a cycle unless o_stall.
// Depends on ctk_pkg and c_token_classifier_top_defines.svh.
module ctk_outq #(
    parameter int DEPTH = ctk_pkg::CTK_QDEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctk_pkg::t_push     i_push,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output ctk_pkg::t_out_beat o_data
);
    import ctk_pkg::*;
    `include "c_token_classifier_top_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_out_beat       r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr, r_rd, n_rd, wr_inc;
    logic [CW-1:0]   r_count, n_count;
    logic            pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr_inc  = ptr_inc(r_wr);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_stall = (r_count > CW'(DEPTH - 2));

    always_comb begin
        n_count = r_count + CW'(i_push.num) - CW'(pop);
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        case (i_push.num)
            2'd1:    n_wr = wr_inc;
            2'd2:    n_wr = ptr_inc(wr_inc);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_inc] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `CTK_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push.num != 2'd0, !o_stall)
    `CTK_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push.num != 2'd0 && !pop, o_valid)
    `CTK_ASSERT_IMPL(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wr == r_rd)

endmodule

[tb/tb.sv]
// Self-checking testbench for c_token_classifier_top: random and directed byte streams,
// a built-in lexer that predicts each token class, and a beat-by-beat result check.
// Depends on ctk_pkg and the c_token_classifier_top RTL.
`timescale 1ns / 1ps

module tb;
    import ctk_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int NUM_WORDS    = 27;
    localparam int NUM_KEYWORDS = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_BYTES  = 210;

    localparam string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    localparam string DIGITS = "0123456789";
    localparam string OP_CHARS = "+-<=!>/*.";
    localparam string NUMISH = "0123456789.xe";

    string lex_words [NUM_WORDS] = '{
        "const", "int", "typedef", "float", "struct", "double", "enum", "long",
        "break", "static", "return", "void", "extern", "char", "union", "goto",
        "+", "-", "<=", "=", "!=", "==", "<", ">=", ">", "/", "*"
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_beat   i_in_data   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_beat  o_out_data;

    // lexer state of the pending token
    logic [3:0]            tok_len;
    logic [NUM_WORDS-1:0]  word_cand;
    logic                  all_dig;
    logic [1:0]            dot_cnt;
    logic                  non_num_seen;
    logic                  ident_chars;
    logic                  lead_digit;

    t_in_beat  byte_q [$];
    t_out_beat token_results_q [$];
    t_out_beat want;

    int  items_queued    = 0;
    int  bytes_taken     = 0;
    int  beats_checked   = 0;
    int  mismatch_cnt    = 0;
    int  cycle_cnt       = 0;
    int  in_blocked      = 0;
    int  class_seen [7]  = '{default: 0};
    bit  in_taken        = 1'b0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    int  send_idle_pct   = 0;
    int  recv_idle_pct   = 0;
    bit  hold_req        = 1'b0;
    int  hold_left       = 0;
    int  phase;
    int  target;

    c_token_classifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic clear_token();
        tok_len      = 4'd0;
        word_cand    = '1;
        all_dig      = 1'b1;
        dot_cnt      = 2'd0;
        non_num_seen = 1'b0;
        ident_chars  = 1'b1;
        lead_digit   = 1'b0;
    endtask

    function automatic t_class token_class_now();
        logic [NUM_WORDS-1:0] hits;
        hits = '0;
        if (all_dig) begin
            return CLS_INTEGER;
        end
        for (int k = 0; k < NUM_WORDS; k++) begin
            hits[k] = word_cand[k] && (tok_len == lex_words[k].len());
        end
        if (|hits[NUM_KEYWORDS-1:0]) begin
            return CLS_RESERVED;
        end
        if (|hits) begin
            return CLS_OPERATOR;
        end
        if (dot_cnt == 2'd1 && !non_num_seen) begin
            return CLS_FLOAT;
        end
        if (ident_chars && !lead_digit) begin
            return CLS_VARIABLE;
        end
        return CLS_ERROR;
    endfunction

    // advance the lexer by one beat and queue the classes it produces
    task automatic lex_step(input t_in_beat b);
        logic [7:0] c;
        logic       is_ws;
        logic       dig;
        logic       wch;
        c     = b.char_code;
        is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        dig   = (c >= "0" && c <= "9");
        wch   = dig || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        if (b.end_of_input || is_ws) begin
            if (tok_len != 0) begin
                token_results_q.push_back(t_out_beat'{token_class_now(), 1'b1});
            end
            clear_token();
        end else if (c == CH_SEMI) begin
            if (tok_len != 0) begin
                token_results_q.push_back(t_out_beat'{token_class_now(), 1'b0});
            end
            token_results_q.push_back(t_out_beat'{CLS_STMT_END, 1'b1});
            clear_token();
        end else begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (word_cand[k] && (tok_len >= lex_words[k].len()
                        || lex_words[k][tok_len] != c)) begin
                    word_cand[k] = 1'b0;
                end
            end
            if (!dig) begin
                all_dig = 1'b0;
            end
            if (c == CH_DOT) begin
                if (dot_cnt < 2'd2) begin
                    dot_cnt = dot_cnt + 2'd1;
                end
            end else if (!dig) begin
                non_num_seen = 1'b1;
            end
            if (!wch) begin
                ident_chars = 1'b0;
            end
            if (tok_len == 0) begin
                lead_digit = dig;
            end
            if (tok_len < POS_MAX) begin
                tok_len = tok_len + 4'd1;
            end
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        byte_q.push_back(t_in_beat'{c, 1'b0});
        items_queued++;
    endtask

    task automatic send_eoi();
        byte_q.push_back(t_in_beat'{8'($urandom_range(0, 255)), 1'b1});
        items_queued++;
    endtask

    task automatic send_word(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic send_from(input string set, input int n);
        for (int i = 0; i < n; i++) begin
            send_char(set[$urandom_range(0, set.len() - 1)]);
        end
    endtask

    task automatic send_separator();
        int n;
        n = $urandom_range(0, 9);
        if (n == 9) begin
            send_char(8'($urandom_range(9, 13)));
            send_char($urandom_range(0, 1) ? CH_SEMI : 8'h20);
        end else if (n == 8) begin
            send_eoi();
        end else if (n >= 5) begin
            send_char(CH_SEMI);
        end else if (n == 4) begin
            send_char(8'($urandom_range(9, 13)));
        end else begin
            send_char(8'h20);
        end
    endtask

    task automatic send_random_token();
        string w;
        int    n;
        case ($urandom_range(0, 11))
            0, 1: send_word(lex_words[$urandom_range(0, NUM_KEYWORDS - 1)]);
            2:    send_word(lex_words[$urandom_range(NUM_KEYWORDS, NUM_WORDS - 1)]);
            3:    send_from(DIGITS, $urandom_range(1, 10));
            4: begin
                send_from(DIGITS, $urandom_range(0, 3));
                send_char(CH_DOT);
                send_from(DIGITS, $urandom_range(0, 3));
            end
            5, 6: begin
                send_from(ALNUM.substr(0, 52), 1);
                send_from(ALNUM, $urandom_range(0, 9));
            end
            7: begin
                w = lex_words[$urandom_range(0, NUM_WORDS - 1)];
                n = $urandom_range(1, w.len());
                send_word(w.substr(0, n - 1));
                if ($urandom_range(0, 1)) begin
                    send_from(ALNUM, 1);
                end
            end
            8:  send_from(NUMISH, $urandom_range(1, 6));
            9: begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) begin
                    send_char(8'($urandom_range(0, 255)));
                end
            end
            10: send_from(OP_CHARS, $urandom_range(1, 3));
            default: send_from(ALNUM, $urandom_range(9, 14));
        endcase
        send_separator();
    endtask

    // wait until every queued byte went in and every predicted class came out
    task automatic drain_all();
        while (byte_q.size() != 0 || i_in_valid || token_results_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (byte_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                send_gap = $urandom_range(0, 6);
                i_in_valid <= 1'b0;
            end else begin
                i_in_data  <= byte_q.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            i_out_stall <= 1'b1;
        end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (token_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat class=%0d last=%0b",
                                              o_out_data.token_class, o_out_data.last_of_run));
                end else begin
                    want = token_results_q.pop_front();
                    beats_checked++;
                    if (o_out_data.token_class !== want.token_class) begin
                        report_mismatch($sformatf("token_class %0d, expected %0d",
                                                  o_out_data.token_class, want.token_class));
                    end
                    if (o_out_data.last_of_run !== want.last_of_run) begin
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  o_out_data.last_of_run, want.last_of_run));
                    end
                    class_seen[want.token_class]++;
                end
            end
            if (i_in_valid && o_in_stall) begin
                in_blocked++;
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                bytes_taken++;
                lex_step(i_in_data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[c_token_classifier_top] ERROR");
            $finish;
        end
    end

    initial begin
        clear_token();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_char(CH_SEMI);
        send_char(8'h20);
        send_eoi();
        send_word("typedef");
        send_char(CH_SEMI);
        send_char(CH_DOT);
        send_char(8'h20);
        send_word(">=");
        send_char(8'h09);
        send_char(8'h00);
        send_char(8'hFF);
        send_eoi();
        send_word("_Z9");
        send_char(8'h0D);
        send_word("09");
        send_char(CH_SEMI);
        drain_all();

        for (phase = 0; phase < 8; phase++) begin
            while (byte_q.size() > 4) begin
                @(negedge i_clk);
            end
            case (phase)
                0: begin send_idle_pct = 15; recv_idle_pct = 15; end
                1: begin send_idle_pct = 0;  recv_idle_pct = 30; end
                2: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                3: begin send_idle_pct = 30; recv_idle_pct = 0;  end
                5: begin send_idle_pct = 50; recv_idle_pct = 50; end
                7: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: begin
                    send_idle_pct = $urandom_range(5, 40);
                    recv_idle_pct = $urandom_range(5, 40);
                end
            endcase
            target = items_queued + PHASE_BYTES;
            while (items_queued < target) begin
                send_random_token();
            end
            // receiver backs off while the sender keeps pushing bytes
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            if (phase == 4) begin
                drain_all();
            end
        end

        drain_all();
        repeat (20) @(negedge i_clk);

        $display("run covered %0d bytes and %0d result beats, input stalled on %0d cycles",
                 bytes_taken, beats_checked, in_blocked);
        $display("classes err/rsv/int/flt/op/var/end: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3],
                 class_seen[4], class_seen[5], class_seen[6]);
        if (mismatch_cnt == 0 && token_results_q.size() == 0) begin
            $display("[c_token_classifier_top] OK");
        end else begin
            $display("[c_token_classifier_top] ERROR");
        end
        $finish;
    end

endmodule
